// File: rtl/rgbhsl_pkg.sv
`default_nettype none

package rgbhsl_pkg;

  localparam int CHAN_W = 8;
  localparam int PIX_W  = 3 * CHAN_W;
  localparam int SUM_W  = CHAN_W + 1;
  localparam int HUE_W  = 9;
  localparam int PCT_W  = 7;

  // Shared long-division datapath: two lanes, one quotient bit per stage
  localparam int NUM_W  = 18;
  localparam int DEN_W  = 9;
  localparam int Q_W    = 9;
  localparam int LANES  = 2;

  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;

  // Lightness is round(10 * sum / 51) = floor((20 * sum + 51) / 102), taken as
  // a multiply by 10281 / 2^20; the error stays below one step up to sum 510
  localparam int LIG_W     = 27;
  localparam int LIG_SHIFT = 20;
  localparam logic [LIG_W-1:0] LIG_MUL = LIG_W'(205620);  // 20 * 10281
  localparam logic [LIG_W-1:0] LIG_ADD = LIG_W'(524331);  // 51 * 10281
  // Saturation numerator is 2 * 100 * d, plus the denominator for rounding
  localparam logic [NUM_W-1:0] SAT_SCALE = NUM_W'(200);
  localparam logic [NUM_W-1:0] HUE_STEP  = NUM_W'(60);
  localparam logic [NUM_W-1:0] HUE_GREEN = NUM_W'(120);
  localparam logic [NUM_W-1:0] HUE_BLUE  = NUM_W'(240);
  localparam logic [NUM_W-1:0] HUE_WRAP  = NUM_W'(360);
  localparam logic [SUM_W-1:0] SUM_MID   = SUM_W'(255);
  localparam logic [SUM_W-1:0] SUM_TOP   = SUM_W'(510);

  typedef logic [NUM_W-1:0] num_t;
  typedef logic [DEN_W-1:0] den_t;
  typedef logic [Q_W-1:0]   quo_t;

endpackage

`default_nettype wire

// File: rtl/rgbhsl_if.sv
`default_nettype none

interface rgbhsl_pix_if import rgbhsl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] packed_color;

  modport source (output valid, output packed_color, input ready);
  modport sink (input valid, input packed_color, output ready);
  modport monitor (input valid, input packed_color, input ready);
endinterface

interface rgbhsl_hsl_if import rgbhsl_pkg::*;;
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue_degrees;
  logic [PCT_W-1:0] saturation_pct;
  logic [PCT_W-1:0] lightness_pct;

  modport source (output valid, output hue_degrees, output saturation_pct,
                  output lightness_pct, input ready);
  modport sink (input valid, input hue_degrees, input saturation_pct,
                input lightness_pct, output ready);
  modport monitor (input valid, input hue_degrees, input saturation_pct,
                   input lightness_pct, input ready);
endinterface

`default_nettype wire

// File: rtl/rgbhsl_div_pipe.sv
`default_nettype none

module rgbhsl_div_pipe import rgbhsl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  num_t                  in_num [LANES],
  input  den_t                  in_den [LANES],
  input  wire logic [PCT_W-1:0] in_tag,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output quo_t                  out_quo [LANES],
  output logic [PCT_W-1:0]      out_tag
);

  localparam int STAGES = Q_W;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   go;
  num_t rem [STAGES][LANES];
  den_t dv  [STAGES][LANES];
  quo_t quo [STAGES][LANES];
  logic [PCT_W-1:0] tag [STAGES];

  logic [STAGES-1:0] src_vld;
  num_t src_rem  [STAGES][LANES];
  den_t src_dv   [STAGES][LANES];
  quo_t src_quo  [STAGES][LANES];
  logic [PCT_W-1:0] src_tag [STAGES];
  num_t rem_next [STAGES][LANES];
  quo_t quo_next [STAGES][LANES];

  // A stage advances when it is empty or the stage after it advances
  always_comb begin
    go[STAGES] = out_ready;
    for (int s = STAGES - 1; s >= 0; s--) begin
      go[s] = !vld[s] || go[s+1];
    end
  end

  always_comb begin
    src_vld[0] = in_valid;
    src_tag[0] = in_tag;
    for (int l = 0; l < LANES; l++) begin
      src_rem[0][l] = in_num[l];
      src_dv[0][l]  = in_den[l];
      src_quo[0][l] = '0;
    end
    for (int s = 1; s < STAGES; s++) begin
      src_vld[s] = vld[s-1];
      src_tag[s] = tag[s-1];
      for (int l = 0; l < LANES; l++) begin
        src_rem[s][l] = rem[s-1][l];
        src_dv[s][l]  = dv[s-1][l];
        src_quo[s][l] = quo[s-1][l];
      end
    end
  end

  // Stage s decides quotient bit Q_W-1-s by one trial subtraction
  always_comb begin
    num_t trial;
    for (int s = 0; s < STAGES; s++) begin
      for (int l = 0; l < LANES; l++) begin
        trial = num_t'(src_dv[s][l]) << (Q_W - 1 - s);
        if (src_rem[s][l] >= trial) begin
          rem_next[s][l] = src_rem[s][l] - trial;
          quo_next[s][l] = src_quo[s][l] | (quo_t'(1) << (Q_W - 1 - s));
        end else begin
          rem_next[s][l] = src_rem[s][l];
          quo_next[s][l] = src_quo[s][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int s = 0; s < STAGES; s++) begin
        if (go[s]) vld[s] <= src_vld[s];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < STAGES; s++) begin
      if (go[s]) begin
        tag[s] <= src_tag[s];
        for (int l = 0; l < LANES; l++) begin
          rem[s][l] <= rem_next[s][l];
          dv[s][l]  <= src_dv[s][l];
          quo[s][l] <= quo_next[s][l];
        end
      end
    end
  end

  assign in_ready  = go[0];
  assign out_valid = vld[STAGES-1];
  assign out_tag   = tag[STAGES-1];

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      out_quo[l] = quo[STAGES-1][l];
    end
  end

endmodule

`default_nettype wire

// File: rtl/rgb_to_hsl_converter.sv
// RGB to HSL pixel converter.
//
// pixel  : sink channel, one packed 24-bit pixel per transaction, red in
//          bits 23:16, green in 15:8, blue in 7:0.
// result : source channel, hue in degrees (0..360), saturation and
//          lightness in percent (0..100), all rounded half up.
//
// Throughput: one pixel per cycle, sustained, as long as result.ready is
// high. There are 11 register stages: extremes and sector, numerators,
// denominators and lightness, then nine stages of a two-lane restoring
// divider that settles one quotient bit per stage while the lightness
// rides along.
//
// Reset (rst, synchronous) empties the pipeline; no result is shown until
// a new pixel has passed through. When the receiver stalls, the last stage
// holds its result and earlier stages keep filling their empty slots, so
// pixel.ready drops only once every stage holds a pixel.
`default_nettype none

module rgb_to_hsl_converter import rgbhsl_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  rgbhsl_pix_if.sink    pixel,
  rgbhsl_hsl_if.source  result
);

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  logic [CHAN_W-1:0] red, green, blue;
  logic [CHAN_W-1:0] mx, mn, hx, hy;
  sector_t           sec;

  logic              s1_vld;
  logic              s1_en;
  sector_t           s1_sec;
  logic [CHAN_W-1:0] s1_hx, s1_hy, s1_d;
  logic [SUM_W-1:0]  s1_sum;

  logic              s2_vld;
  logic              s2_en;
  num_t              s2_num [LANES];
  den_t              s2_den [LANES];
  logic [PCT_W-1:0]  s2_lig;
  num_t              s2_num_next [LANES];
  den_t              s2_den_next [LANES];
  logic [PCT_W-1:0]  s2_lig_next;

  logic              div_ready;
  quo_t              div_quo [LANES];

  assign red   = pixel.packed_color[3*CHAN_W-1:2*CHAN_W];
  assign green = pixel.packed_color[2*CHAN_W-1:CHAN_W];
  assign blue  = pixel.packed_color[CHAN_W-1:0];

  // Red wins ties over green, green over blue
  always_comb begin
    if (red >= green && red >= blue) begin
      sec = SEC_RED;
      mx  = red;
      hx  = green;
      hy  = blue;
    end else if (green >= blue) begin
      sec = SEC_GREEN;
      mx  = green;
      hx  = blue;
      hy  = red;
    end else begin
      sec = SEC_BLUE;
      mx  = blue;
      hx  = red;
      hy  = green;
    end
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
  end

  assign s2_en = !s2_vld || div_ready;
  assign s1_en = !s1_vld || s2_en;
  assign pixel.ready = s1_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
    end else begin
      if (s1_en) s1_vld <= pixel.valid;
      if (s2_en) s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_sec <= sec;
      s1_hx  <= hx;
      s1_hy  <= hy;
      s1_d   <= mx - mn;
      s1_sum <= SUM_W'(mx) + SUM_W'(mn);
    end
  end

  // Each lane divides floor((2p + q) / (2q)) to round p/q half up
  always_comb begin
    logic              pos;
    logic [CHAN_W-1:0] mag;
    logic [SUM_W-1:0]  wrap_sum;
    logic [CHAN_W-1:0] sat_den;
    logic [LIG_W-1:0]  lig_prod;
    num_t              d_w, base, step, hue_val;

    d_w  = num_t'(s1_d);
    pos  = s1_hx >= s1_hy;
    mag  = pos ? (s1_hx - s1_hy) : (s1_hy - s1_hx);
    step = num_t'(mag) * HUE_STEP;
    case (s1_sec)
      SEC_RED:   base = pos ? '0 : d_w * HUE_WRAP;
      SEC_GREEN: base = d_w * HUE_GREEN;
      SEC_BLUE:  base = d_w * HUE_BLUE;
      default:   base = '0;
    endcase
    hue_val = pos ? (base + step) : (base - step);

    wrap_sum = SUM_TOP - s1_sum;
    sat_den  = (s1_sum < SUM_MID) ? s1_sum[CHAN_W-1:0] : wrap_sum[CHAN_W-1:0];

    if (s1_d == '0) begin
      // gray: zero over one yields zero hue and saturation
      s2_num_next[LANE_HUE] = '0;
      s2_den_next[LANE_HUE] = den_t'(1);
      s2_num_next[LANE_SAT] = '0;
      s2_den_next[LANE_SAT] = den_t'(1);
    end else begin
      s2_num_next[LANE_HUE] = (hue_val << 1) + d_w;
      s2_den_next[LANE_HUE] = {s1_d, 1'b0};
      s2_num_next[LANE_SAT] = d_w * SAT_SCALE + num_t'(sat_den);
      s2_den_next[LANE_SAT] = {sat_den, 1'b0};
    end

    lig_prod    = LIG_W'(s1_sum) * LIG_MUL + LIG_ADD;
    s2_lig_next = lig_prod[LIG_SHIFT +: PCT_W];
  end

  always_ff @(posedge clk) begin
    if (s2_en) begin
      s2_lig <= s2_lig_next;
      for (int l = 0; l < LANES; l++) begin
        s2_num[l] <= s2_num_next[l];
        s2_den[l] <= s2_den_next[l];
      end
    end
  end

  rgbhsl_div_pipe u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_vld),
    .in_ready  (div_ready),
    .in_num    (s2_num),
    .in_den    (s2_den),
    .in_tag    (s2_lig),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .out_quo   (div_quo),
    .out_tag   (result.lightness_pct)
  );

  assign result.hue_degrees    = div_quo[LANE_HUE][HUE_W-1:0];
  assign result.saturation_pct = div_quo[LANE_SAT][PCT_W-1:0];

endmodule

`default_nettype wire

// File: rtl/rgbhsl_checker.sv
`default_nettype none

module rgbhsl_checker import rgbhsl_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             pix_valid,
  input  wire logic             pix_ready,
  input  wire logic             res_valid,
  input  wire logic             res_ready,
  input  wire logic [HUE_W-1:0] hue_degrees,
  input  wire logic [PCT_W-1:0] saturation_pct,
  input  wire logic [PCT_W-1:0] lightness_pct
);

  localparam logic [HUE_W-1:0] HUE_MAX = HUE_W'(360);
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // a stalled result keeps its transaction unchanged
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(hue_degrees)
      && $stable(saturation_pct) && $stable(lightness_pct))
    else $error("stalled result changed");

  // reset drains the pipeline
  a_reset: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // input only backs up once the output stage is stuck
  a_ready: assert property (@(posedge clk) disable iff (rst)
    (!res_valid || res_ready) |-> pix_ready)
    else $error("pixel not ready with output stage free");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> hue_degrees <= HUE_MAX
      && saturation_pct <= PCT_MAX && lightness_pct <= PCT_MAX)
    else $error("result out of range");

  // pixel.valid is watched by the stimulus side only
  logic unused_pix_valid;
  assign unused_pix_valid = pix_valid;

endmodule

bind rgb_to_hsl_converter rgbhsl_checker u_chk (
  .clk            (clk),
  .rst            (rst),
  .pix_valid      (pixel.valid),
  .pix_ready      (pixel.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .hue_degrees    (result.hue_degrees),
  .saturation_pct (result.saturation_pct),
  .lightness_pct  (result.lightness_pct)
);

`default_nettype wire

// File: test/tb_top.sv
module tb_top import rgbhsl_pkg::*; ();

  localparam int RANDOM_PIXELS = 1900;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int LONG_HOLD     = 300;
  localparam int TAIL_CYCLES   = 20;
  localparam int N_DIRECTED    = 18;

  typedef struct packed {
    logic [HUE_W-1:0] hue;
    logic [PCT_W-1:0] sat;
    logic [PCT_W-1:0] lig;
  } hsl_t;

  typedef struct packed {
    logic [PIX_W-1:0] px;
    logic             known;
    hsl_t             hsl;
  } pixel_row_t;

  // Rows with known set carry a hand-computed result; the rest go to the predictor.
  localparam pixel_row_t DIRECTED_PIXELS [N_DIRECTED] = '{
    '{24'h000000, 1'b1, '{9'd0,   7'd0,   7'd0}},
    '{24'hFFFFFF, 1'b1, '{9'd0,   7'd0,   7'd100}},
    '{24'hFF0000, 1'b1, '{9'd0,   7'd100, 7'd50}},
    '{24'h00FF00, 1'b1, '{9'd120, 7'd100, 7'd50}},
    '{24'h0000FF, 1'b1, '{9'd240, 7'd100, 7'd50}},
    '{24'hFFFF00, 1'b1, '{9'd60,  7'd100, 7'd50}},
    '{24'h00FFFF, 1'b1, '{9'd180, 7'd100, 7'd50}},
    '{24'hFF00FF, 1'b1, '{9'd300, 7'd100, 7'd50}},
    '{24'h808080, 1'b1, '{9'd0,   7'd0,   7'd50}},
    '{24'h010101, 1'b1, '{9'd0,   7'd0,   7'd0}},
    '{24'h010000, 1'b1, '{9'd0,   7'd100, 7'd0}},
    '{24'hFFFFFE, 1'b1, '{9'd60,  7'd100, 7'd100}},
    '{24'hFF0001, 1'b1, '{9'd360, 7'd100, 7'd50}},
    '{24'h008080, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{24'h807F7F, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{24'hFE0000, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{24'h123456, 1'b0, '{9'd0,   7'd0,   7'd0}},
    '{24'h7F80FF, 1'b0, '{9'd0,   7'd0,   7'd0}}
  };

  logic clk;
  logic rst;

  rgbhsl_pix_if pix_ch ();
  rgbhsl_hsl_if hsl_ch ();

  rgb_to_hsl_converter u_dut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_ch),
    .result (hsl_ch)
  );

  hsl_t hsl_pending [$];
  int   fail_count = 0;
  int   cycle_count = 0;
  int   results_seen = 0;
  int   hold_left = 0;
  int   next_hold_at = 400;
  bit   tx_quiet = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  function automatic int unsigned round_half_up(input int unsigned num,
                                                input int unsigned den);
    return (2 * num + den) / (2 * den);
  endfunction

  function automatic hsl_t predict_hsl(input logic [PIX_W-1:0] px);
    int unsigned r, g, b, hi, lo, d, sum, den, num;
    hsl_t res;
    r = 32'(px[23:16]);
    g = 32'(px[15:8]);
    b = 32'(px[7:0]);
    hi = r;
    lo = r;
    if (g > hi) hi = g;
    if (b > hi) hi = b;
    if (g < lo) lo = g;
    if (b < lo) lo = b;
    d = hi - lo;
    sum = hi + lo;
    res.lig = PCT_W'(round_half_up(10 * sum, 51));
    res.hue = '0;
    res.sat = '0;
    if (d != 0) begin
      den = (sum < 255) ? sum : (510 - sum);
      res.sat = PCT_W'(round_half_up(100 * d, den));
      // red wins ties, then green; negative offsets wrap by adding 360
      if (hi == r) begin
        num = (g >= b) ? 60 * (g - b) : 360 * d - 60 * (b - g);
      end else if (hi == g) begin
        num = (b >= r) ? 120 * d + 60 * (b - r) : 120 * d - 60 * (r - b);
      end else begin
        num = (r >= g) ? 240 * d + 60 * (r - g) : 240 * d - 60 * (g - r);
      end
      res.hue = HUE_W'(round_half_up(num, d));
    end
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] random_pixel();
    logic [7:0]  hi, lo, c;
    logic [7:0]  edges [6];
    logic [31:0] word;
    edges = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
    word = $urandom();
    case ($urandom_range(0, 9))
      0: begin
        c = word[7:0];
        return {c, c, c};
      end
      1: begin
        hi = word[7:0];
        lo = 8'($urandom_range(0, hi));
        case ($urandom_range(0, 2))
          0:       return {hi, hi, lo};
          1:       return {hi, lo, hi};
          default: return {lo, hi, hi};
        endcase
      end
      2: begin
        // red on top with blue just above green: hue right under the wrap
        hi = 8'($urandom_range(1, 255));
        lo = 8'($urandom_range(0, hi - 1));
        return {hi, lo, lo + 8'd1};
      end
      3: begin
        return {edges[$urandom_range(0, 5)], edges[$urandom_range(0, 5)],
                edges[$urandom_range(0, 5)]};
      end
      default: return word[PIX_W-1:0];
    endcase
  endfunction

  task automatic send_pixel(input logic [PIX_W-1:0] px, input hsl_t want);
    while (!tx_quiet && $urandom_range(0, 99) < 15) begin
      pix_ch.valid <= 1'b0;
      @(posedge clk);
    end
    pix_ch.valid        <= 1'b1;
    pix_ch.packed_color <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    hsl_pending.push_back(want);
  endtask

  task automatic drain_results();
    pix_ch.valid <= 1'b0;
    while (hsl_pending.size() != 0) @(posedge clk);
  endtask

  task automatic check_result();
    hsl_t want;
    if (hsl_pending.size() == 0) begin
      $error("unexpected result: hue %0d sat %0d lig %0d", hsl_ch.hue_degrees,
             hsl_ch.saturation_pct, hsl_ch.lightness_pct);
      fail_count++;
    end else begin
      want = hsl_pending.pop_front();
      if (hsl_ch.hue_degrees !== want.hue) begin
        $error("hue_degrees mismatch: expected %0d, actual %0d", want.hue,
               hsl_ch.hue_degrees);
        fail_count++;
      end
      if (hsl_ch.saturation_pct !== want.sat) begin
        $error("saturation_pct mismatch: expected %0d, actual %0d", want.sat,
               hsl_ch.saturation_pct);
        fail_count++;
      end
      if (hsl_ch.lightness_pct !== want.lig) begin
        $error("lightness_pct mismatch: expected %0d, actual %0d", want.lig,
               hsl_ch.lightness_pct);
        fail_count++;
      end
    end
  endtask

  // Result side: check every transaction, idle at random, hold off for long stretches.
  initial begin
    hsl_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && hsl_ch.valid && hsl_ch.ready) begin
        check_result();
        results_seen++;
      end
      if (results_seen >= next_hold_at) begin
        hold_left = LONG_HOLD;
        next_hold_at += 900;
      end
      if (hold_left > 0) begin
        hold_left--;
        hsl_ch.ready <= 1'b0;
      end else if (!(results_seen >= 800 && results_seen < 1100) &&
                   $urandom_range(0, 99) < 15) begin
        hsl_ch.ready <= 1'b0;
      end else begin
        hsl_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    logic [PIX_W-1:0] px;
    hsl_t             want;
    rst                 <= 1'b1;
    pix_ch.valid        <= 1'b0;
    pix_ch.packed_color <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_DIRECTED; i++) begin
      want = DIRECTED_PIXELS[i].known ? DIRECTED_PIXELS[i].hsl
                                      : predict_hsl(DIRECTED_PIXELS[i].px);
      send_pixel(DIRECTED_PIXELS[i].px, want);
    end
    drain_results();

    for (int i = 0; i < RANDOM_PIXELS; i++) begin
      tx_quiet = (i >= 700 && i < 1000);
      if (i == 1200) drain_results();
      px = random_pixel();
      send_pixel(px, predict_hsl(px));
    end
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fail_count == 0 && hsl_pending.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
